FILE: sv/cbor_item_validator_assert.svh
// ----------------------------------------------------------------------------
// cbor_item_validator assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CBOR_ITEM_VALIDATOR_ASSERT_SVH
`define CBOR_ITEM_VALIDATOR_ASSERT_SVH

// Same-cycle implication
`define CBV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CBV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/cborv_pkg.sv
// ----------------------------------------------------------------------------
// cborv_pkg
// Types and codes shared by the CBOR item validator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cborv_pkg;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_ARG,
        PH_PAYLOAD,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_EMIT
    } state_t;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_RESERVED  = 3'd1;
    localparam logic [2:0] STAT_TRUNCATED = 3'd2;
    localparam logic [2:0] STAT_TOO_DEEP  = 3'd3;
    localparam logic [2:0] STAT_TOO_LONG  = 3'd4;

    localparam logic [2:0] MAJ_BSTR  = 3'd2;
    localparam logic [2:0] MAJ_TSTR  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;
    localparam logic [2:0] MAJ_TAG   = 3'd6;

    localparam logic [4:0] MINOR_ARG1   = 5'd24;
    localparam logic [4:0] MINOR_ARG8   = 5'd27;
    localparam logic [4:0] MINOR_INDEF  = 5'd31;
    localparam logic [7:0] BREAK_BYTE   = 8'hFF;

endpackage

FILE: sv/cbor_item_validator.sv
// ----------------------------------------------------------------------------
// cbor_item_validator
// Streaming well-formedness check of the first CBOR item in a byte buffer.
// ----------------------------------------------------------------------------
// Bytes enter one per request on the slave side; s_tlast marks the final byte
// of a buffer, and only that byte yields a result on the master side.
// A finished item adds one cycle for every nesting level
// that it closes while an enclosing level stays open, since the enclosing
// container's count must be read back from the nesting memory (one-cycle read
// port); closing the outermost level costs nothing extra. After the final byte,
// the emit state loads the result register. The innermost open container
// is held in a register; outer levels live in the memory. A result still
// waiting in the output register stalls the input only once the next
// buffer's last byte has been taken.
`timescale 1ns / 1ps
`include "cbor_item_validator_assert.svh"

module cbor_item_validator #(
    parameter int MAX_DEPTH = 16,
    parameter int LEN_BITS  = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] well_formed, [3:1] status,
                                   // [35:4] item_length, [39:36] zero
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam logic [LEN_BITS-1:0] LEN_MASK = '1;

    // Control and datapath registers
    cborv_pkg::state_t state_reg, state_next;
    cborv_pkg::phase_t phase_reg, phase_next;
    logic [3:0]          arg_left_reg, arg_left_next;
    logic [63:0]         arg_val_reg, arg_val_next;
    logic [2:0]          pend_major_reg, pend_major_next;
    logic [LEN_BITS-1:0] payload_left_reg, payload_left_next;
    logic [LW-1:0]       level_reg, level_next;
    logic [LEN_BITS:0]   top_reg, top_next;     // innermost open level
    logic [LEN_BITS-1:0] bytes_seen_reg, bytes_seen_next;
    logic [LEN_BITS-1:0] first_len_reg, first_len_next;
    logic                complete_reg, complete_next;
    logic [2:0]          err_reg, err_next;
    logic                last_reg, last_next;

    logic                out_valid_reg;
    logic                out_wf_reg;
    logic [2:0]          out_status_reg;
    logic [31:0]         out_len_reg;

    // Nesting memory: outer levels, bit LEN_BITS flags an indefinite container
    logic [LEN_BITS:0] stack_mem [MAX_DEPTH];
    logic [LEN_BITS:0] rd_data_reg;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [LEN_BITS:0] mem_wdata;
    logic              pop_req;
    logic [AW-1:0]     mem_raddr;

    logic accept_in;
    logic emit_fire;

    // Working values of the byte step
    logic [4:0]          minor;
    logic [2:0]          major;
    logic                wrapped;
    logic                act_en;
    logic [2:0]          act_major;
    logic [63:0]         act_value;
    logic                act_indef;
    logic                do_close;
    logic                do_push;
    logic [LEN_BITS:0]   push_entry;
    logic [LEN_BITS:0]   close_top;
    logic [LEN_BITS-1:0] cnt;
    logic [LEN_BITS-1:0] room;
    logic [3:0]          arg_dec;

    assign accept_in = s_tvalid && s_tready;
    assign emit_fire = (state_reg == cborv_pkg::ST_EMIT) && (!out_valid_reg || m_tready);

    // Byte step and level closing
    always_comb begin
        phase_next        = phase_reg;
        arg_left_next     = arg_left_reg;
        arg_val_next      = arg_val_reg;
        pend_major_next   = pend_major_reg;
        payload_left_next = payload_left_reg;
        level_next        = level_reg;
        top_next          = top_reg;
        bytes_seen_next   = bytes_seen_reg;
        first_len_next    = first_len_reg;
        complete_next     = complete_reg;
        err_next          = err_reg;
        last_next         = last_reg;
        mem_we            = 1'b0;
        mem_waddr         = AW'(level_reg - LW'(1));
        mem_wdata         = top_reg;
        pop_req           = 1'b0;
        mem_raddr         = '0;
        minor             = s_tdata[4:0];
        major             = s_tdata[7:5];
        wrapped           = (pend_major_reg == cborv_pkg::MAJ_TAG);
        act_en            = 1'b0;
        act_major         = major;
        act_value         = {59'd0, minor};
        act_indef         = 1'b0;
        do_close          = 1'b0;
        do_push           = 1'b0;
        push_entry        = '0;
        close_top         = top_reg;
        cnt               = '0;
        room              = LEN_MASK - bytes_seen_reg;
        arg_dec           = arg_left_reg;

        if (state_reg == cborv_pkg::ST_IDLE && accept_in) begin
            last_next = s_tlast;
            if (phase_reg != cborv_pkg::PH_DONE) begin
                if (bytes_seen_reg == LEN_MASK) begin
                    err_next   = cborv_pkg::STAT_TOO_LONG;
                    phase_next = cborv_pkg::PH_DONE;
                end else begin
                    bytes_seen_next = bytes_seen_reg + LEN_BITS'(1);
                    room = LEN_MASK - bytes_seen_next;
                    unique case (phase_reg)
                        cborv_pkg::PH_HEAD: begin
                            pend_major_next = major;
                            if (s_tdata == cborv_pkg::BREAK_BYTE && !wrapped &&
                                level_reg != '0 && top_reg[LEN_BITS]) begin
                                // close the open indefinite container
                                level_next = level_reg - LW'(1);
                                if (level_next == '0) begin
                                    do_close = 1'b1;
                                end else begin
                                    pop_req   = 1'b1;
                                    mem_raddr = AW'(level_next - LW'(1));
                                end
                            end else if (minor < cborv_pkg::MINOR_ARG1) begin
                                act_en = 1'b1;
                            end else if (minor <= cborv_pkg::MINOR_ARG8) begin
                                arg_left_next = 4'd1 << (minor - cborv_pkg::MINOR_ARG1);
                                arg_val_next  = '0;
                                phase_next    = cborv_pkg::PH_ARG;
                            end else if (minor < cborv_pkg::MINOR_INDEF) begin
                                err_next   = cborv_pkg::STAT_RESERVED;
                                phase_next = cborv_pkg::PH_DONE;
                            end else begin
                                act_en    = 1'b1;
                                act_value = '0;
                                act_indef = 1'b1;
                            end
                        end
                        cborv_pkg::PH_ARG: begin
                            arg_val_next = {arg_val_reg[55:0], s_tdata};
                            if (arg_left_reg != 4'd0) begin
                                arg_dec = arg_left_reg - 4'd1;
                            end
                            arg_left_next = arg_dec;
                            if (arg_dec == 4'd0) begin
                                act_en    = 1'b1;
                                act_major = pend_major_reg;
                                act_value = arg_val_next;
                            end
                        end
                        cborv_pkg::PH_PAYLOAD: begin
                            if (payload_left_reg != '0) begin
                                payload_left_next = payload_left_reg - LEN_BITS'(1);
                            end
                            if (payload_left_next == '0) begin
                                phase_next = cborv_pkg::PH_HEAD;
                                do_close   = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase

                    // Head with a known argument or an indefinite length
                    if (act_en) begin
                        phase_next = cborv_pkg::PH_HEAD;
                        priority if (act_major == cborv_pkg::MAJ_BSTR ||
                                     act_major == cborv_pkg::MAJ_TSTR) begin
                            if (act_indef) begin
                                do_close = 1'b1;
                            end else if (act_value > {{(64-LEN_BITS){1'b0}}, room}) begin
                                err_next   = cborv_pkg::STAT_TOO_LONG;
                                phase_next = cborv_pkg::PH_DONE;
                            end else if (act_value == '0) begin
                                do_close = 1'b1;
                            end else begin
                                payload_left_next = act_value[LEN_BITS-1:0];
                                phase_next        = cborv_pkg::PH_PAYLOAD;
                            end
                        end else if (act_major == cborv_pkg::MAJ_ARRAY) begin
                            if (act_indef) begin
                                do_push    = 1'b1;
                                push_entry = {1'b1, {LEN_BITS{1'b0}}};
                            end else if (|act_value[63:LEN_BITS]) begin
                                err_next   = cborv_pkg::STAT_TOO_LONG;
                                phase_next = cborv_pkg::PH_DONE;
                            end else if (act_value == '0) begin
                                do_close = 1'b1;
                            end else begin
                                do_push    = 1'b1;
                                push_entry = {1'b0, act_value[LEN_BITS-1:0]};
                            end
                        end else if (act_major == cborv_pkg::MAJ_MAP) begin
                            if (act_indef) begin
                                do_push    = 1'b1;
                                push_entry = {1'b1, {LEN_BITS{1'b0}}};
                            end else if (|act_value[63:LEN_BITS-1]) begin
                                err_next   = cborv_pkg::STAT_TOO_LONG;
                                phase_next = cborv_pkg::PH_DONE;
                            end else if (act_value == '0) begin
                                do_close = 1'b1;
                            end else begin
                                do_push    = 1'b1;
                                push_entry = {1'b0, act_value[LEN_BITS-2:0], 1'b0};
                            end
                        end else if (act_major == cborv_pkg::MAJ_TAG) begin
                            // hold: the next head is the wrapped item
                        end else begin
                            do_close = 1'b1;
                        end
                    end

                    if (do_push) begin
                        if (level_reg == LW'(MAX_DEPTH)) begin
                            err_next   = cborv_pkg::STAT_TOO_DEEP;
                            phase_next = cborv_pkg::PH_DONE;
                        end else begin
                            // spill the current top to memory
                            mem_we     = (level_reg != '0);
                            top_next   = push_entry;
                            level_next = level_reg + LW'(1);
                        end
                    end
                end
            end
        end else if (state_reg == cborv_pkg::ST_POP) begin
            // reloaded top, then carry on closing
            close_top = rd_data_reg;
            top_next  = rd_data_reg;
            do_close  = 1'b1;
        end else if (emit_fire) begin
            phase_next        = cborv_pkg::PH_HEAD;
            arg_left_next     = '0;
            arg_val_next      = '0;
            pend_major_next   = '0;
            payload_left_next = '0;
            level_next        = '0;
            bytes_seen_next   = '0;
            first_len_next    = '0;
            complete_next     = 1'b0;
            err_next          = cborv_pkg::STAT_OK;
        end

        // Account a finished item in the innermost container
        if (do_close) begin
            if (level_next == '0) begin
                complete_next  = 1'b1;
                first_len_next = bytes_seen_next;
                phase_next     = cborv_pkg::PH_DONE;
            end else if (!close_top[LEN_BITS]) begin
                cnt = close_top[LEN_BITS-1:0] - LEN_BITS'(1);
                if (cnt != '0) begin
                    top_next = {1'b0, cnt};
                end else begin
                    level_next = level_next - LW'(1);
                    if (level_next == '0) begin
                        complete_next  = 1'b1;
                        first_len_next = bytes_seen_next;
                        phase_next     = cborv_pkg::PH_DONE;
                    end else begin
                        pop_req   = 1'b1;
                        mem_raddr = AW'(level_next - LW'(1));
                    end
                end
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cborv_pkg::ST_IDLE: begin
                if (accept_in) begin
                    if (pop_req) begin
                        state_next = cborv_pkg::ST_POP;
                    end else if (s_tlast) begin
                        state_next = cborv_pkg::ST_EMIT;
                    end
                end
            end
            cborv_pkg::ST_POP: begin
                if (!pop_req) begin
                    state_next = last_reg ? cborv_pkg::ST_EMIT : cborv_pkg::ST_IDLE;
                end
            end
            cborv_pkg::ST_EMIT: begin
                if (emit_fire) begin
                    state_next = cborv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cborv_pkg::ST_IDLE;
            end
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_tready = (state_reg == cborv_pkg::ST_IDLE);
        m_tvalid = out_valid_reg;
        m_tdata  = {4'd0, out_len_reg, out_status_reg, out_wf_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= cborv_pkg::ST_IDLE;
            phase_reg        <= cborv_pkg::PH_HEAD;
            arg_left_reg     <= '0;
            arg_val_reg      <= '0;
            pend_major_reg   <= '0;
            payload_left_reg <= '0;
            level_reg        <= '0;
            bytes_seen_reg   <= '0;
            first_len_reg    <= '0;
            complete_reg     <= 1'b0;
            err_reg          <= cborv_pkg::STAT_OK;
            last_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            arg_left_reg     <= arg_left_next;
            arg_val_reg      <= arg_val_next;
            pend_major_reg   <= pend_major_next;
            payload_left_reg <= payload_left_next;
            level_reg        <= level_next;
            bytes_seen_reg   <= bytes_seen_next;
            first_len_reg    <= first_len_next;
            complete_reg     <= complete_next;
            err_reg          <= err_next;
            last_reg         <= last_next;
            if (emit_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (emit_fire) begin
            out_wf_reg     <= complete_reg;
            out_status_reg <= complete_reg ? cborv_pkg::STAT_OK :
                              ((err_reg != cborv_pkg::STAT_OK) ? err_reg :
                               cborv_pkg::STAT_TRUNCATED);
            out_len_reg    <= complete_reg ? 32'(first_len_reg) : 32'd0;
        end
    end

    // Nesting memory; a pop read never meets a write in the same cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (pop_req) begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

    `CBV_ASSERT_NOW(a_level_bound, 1'b1, level_reg <= LW'(MAX_DEPTH),
                    "nesting level beyond depth")
    `CBV_ASSERT_NOW(a_pop_level, state_reg == cborv_pkg::ST_POP, level_reg != '0,
                    "reload with no open level")
    `CBV_ASSERT_NOW(a_done_phase, complete_reg || err_reg != cborv_pkg::STAT_OK,
                    phase_reg == cborv_pkg::PH_DONE, "finished parse not in done phase")
    `CBV_ASSERT_NOW(a_excl, complete_reg, err_reg == cborv_pkg::STAT_OK,
                    "item complete with error")
    `CBV_ASSERT_NEXT(a_emit, emit_fire,
                     m_tvalid && level_reg == '0 && phase_reg == cborv_pkg::PH_HEAD,
                     "result not loaded or state not cleared")

endmodule

FILE: tb/cbor_item_validator_test.sv
// ----------------------------------------------------------------------------
// cbor_item_validator_test
// Self-checking bench: streams CBOR buffers through the validator and
// compares every verdict against an in-bench prediction of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbor_item_validator_test;
    import cborv_pkg::*;

    localparam int DEPTH     = 16;
    localparam longint LMASK = 64'hFFFF_FFFF;
    localparam int LIMIT     = 400000;

    typedef struct packed {
        logic [31:0] len;
        logic [2:0]  status;
        logic        ok;
    } verdict_t;

    typedef struct {
        logic [7:0] b;
        logic       last;
        logic       chk;       // check typed-in verdict too
        verdict_t   want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    cbor_item_validator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------- parser prediction ----------------
    phase_t      p_phase;
    int unsigned p_argleft;
    longint unsigned p_arg;
    logic [2:0]  p_major;
    longint unsigned p_payload;
    longint unsigned p_stack [DEPTH];
    int unsigned p_level;
    longint unsigned p_seen;
    longint unsigned p_first;
    logic        p_done;
    logic [2:0]  p_err;

    verdict_t    verdicts_due[$];
    int          errors = 0;
    int          n_pred = 0;
    int          n_results = 0;
    int          n_ok = 0;
    int          n_bad = 0;
    int          cycles = 0;
    logic        hold_off = 1'b0;
    logic        feeding_done = 1'b0;

    task automatic parser_clear();
        p_phase = PH_HEAD; p_argleft = 0; p_arg = 0; p_major = '0; p_payload = 0;
        p_level = 0; p_seen = 0; p_first = 0; p_done = 1'b0; p_err = STAT_OK;
    endtask

    function automatic void parse_stop(logic [2:0] code);
        p_err = code;
        p_phase = PH_DONE;
    endfunction

    // Account a finished item in the open containers, popping those it closes.
    function automatic void close_item();
        longint unsigned cnt;
        while (p_level > 0) begin
            if (p_stack[p_level-1][32]) return;
            cnt = (p_stack[p_level-1] & LMASK) - 1;
            if (cnt != 0) begin
                p_stack[p_level-1] = cnt;
                return;
            end
            p_level--;
        end
        p_done = 1'b1;
        p_first = p_seen;
        p_phase = PH_DONE;
    endfunction

    function automatic void open_level(longint unsigned entry);
        if (p_level >= DEPTH) begin
            parse_stop(STAT_TOO_DEEP);
            return;
        end
        p_stack[p_level] = entry;
        p_level++;
    endfunction

    function automatic void take_head(logic [2:0] major, longint unsigned v, logic indef);
        longint unsigned mult;
        p_phase = PH_HEAD;
        case (major)
            MAJ_BSTR, MAJ_TSTR: begin
                if (indef) close_item();
                else if (v > LMASK - p_seen) parse_stop(STAT_TOO_LONG);
                else if (v == 0) close_item();
                else begin
                    p_payload = v;
                    p_phase = PH_PAYLOAD;
                end
            end
            MAJ_ARRAY, MAJ_MAP: begin
                mult = (major == MAJ_MAP) ? 2 : 1;
                if (indef) open_level(64'h1_0000_0000);
                else if (v > LMASK / mult) parse_stop(STAT_TOO_LONG);
                else if (v == 0) close_item();
                else open_level(v * mult);
            end
            MAJ_TAG: ;
            default: close_item();
        endcase
    endfunction

    function automatic void head_in(logic [7:0] b);
        logic [4:0] minor;
        logic       wrapped;
        minor = b[4:0];
        wrapped = (p_major == MAJ_TAG);
        p_major = b[7:5];
        if (b == BREAK_BYTE && !wrapped && p_level > 0 && p_stack[p_level-1][32]) begin
            p_level--;
            close_item();
            return;
        end
        if (minor < MINOR_ARG1) take_head(b[7:5], minor, 1'b0);
        else if (minor <= MINOR_ARG8) begin
            p_argleft = 1 << (minor - MINOR_ARG1);
            p_arg = 0;
            p_phase = PH_ARG;
        end else if (minor < MINOR_INDEF) parse_stop(STAT_RESERVED);
        else take_head(b[7:5], 0, 1'b1);
    endfunction

    // Advance the prediction by one byte; queue a verdict on the last byte.
    task automatic predict_byte(logic [7:0] b, logic last);
        verdict_t v;
        if (p_phase != PH_DONE) begin
            if (p_seen >= LMASK) parse_stop(STAT_TOO_LONG);
            else begin
                p_seen++;
                case (p_phase)
                    PH_HEAD: head_in(b);
                    PH_ARG: begin
                        p_arg = (p_arg << 8) | b;
                        if (p_argleft > 0) p_argleft--;
                        if (p_argleft == 0) take_head(p_major, p_arg, 1'b0);
                    end
                    PH_PAYLOAD: begin
                        if (p_payload > 0) p_payload--;
                        if (p_payload == 0) begin
                            p_phase = PH_HEAD;
                            close_item();
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (!last) return;
        if (p_done) v = '{len: p_first[31:0], status: STAT_OK, ok: 1'b1};
        else v = '{len: '0, status: (p_err != STAT_OK) ? p_err : STAT_TRUNCATED, ok: 1'b0};
        verdicts_due.push_back(v);
        n_pred++;
        parser_clear();
    endtask

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("[%0t] mismatch %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // ---------------- result checking ----------------
    always @(posedge aclk) begin
        verdict_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[35:0];
            n_results++;
            if (got.ok) n_ok++; else n_bad++;
            if (verdicts_due.size() == 0) report("unexpected verdict", got, 0);
            else begin
                want = verdicts_due.pop_front();
                if (got.ok !== want.ok) report("well_formed", got.ok, want.ok);
                if (got.status !== want.status) report("status", got.status, want.status);
                if (got.len !== want.len) report("item_length", got.len, want.len);
                if (m_tdata[39:36] !== 4'd0) report("pad bits", m_tdata[39:36], 0);
            end
        end
    end

    // Receiver: own stall pattern, with a long hold-off window and calm stretches.
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else if (cycles % 3000 < 500) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 99) < 65);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout with %0d verdicts outstanding", verdicts_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------- sender ----------------
    int burst_left = 0;

    // Offer one byte, honouring burst/gap pacing, and hold until accepted.
    task automatic send_byte(logic [7:0] b, logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) != 0) ? int'($urandom_range(1, 6)) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_byte(b, last);
        burst_left--;
        @(negedge aclk);
    endtask

    byte unsigned buf_q[$];

    // Build one random item into buf_q: mostly well formed, with random content.
    task automatic gen_item(int depth);
        int kind, n;
        logic [2:0] maj;
        kind = $urandom_range(0, 9);
        if (depth > 3 && kind >= 4 && kind <= 7) kind = 0;
        case (kind)
            0, 1: begin // integer / simple, immediate or sized argument
                maj = ($urandom_range(0, 1)) ? 3'd0 : ($urandom_range(0, 1) ? 3'd1 : 3'd7);
                n = $urandom_range(0, 4);
                if (n == 0) buf_q.push_back({maj, 5'($urandom_range(0, 23))});
                else begin
                    buf_q.push_back({maj, 5'(23 + n)});
                    repeat (1 << (n - 1)) buf_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            2, 3: begin // string
                n = $urandom_range(0, 6);
                maj = $urandom_range(0, 1) ? MAJ_BSTR : MAJ_TSTR;
                if ($urandom_range(0, 1)) buf_q.push_back({maj, 5'(n)});
                else begin
                    buf_q.push_back({maj, MINOR_ARG1});
                    buf_q.push_back(8'(n));
                end
                repeat (n) buf_q.push_back(8'($urandom_range(0, 255)));
            end
            4, 5: begin // array or map, definite or indefinite
                maj = $urandom_range(0, 1) ? MAJ_ARRAY : MAJ_MAP;
                n = $urandom_range(0, 3);
                if ($urandom_range(0, 3) == 0) begin
                    buf_q.push_back({maj, MINOR_INDEF});
                    repeat (n * (maj == MAJ_MAP ? 2 : 1)) gen_item(depth + 1);
                    buf_q.push_back(BREAK_BYTE);
                end else begin
                    buf_q.push_back({maj, 5'(n)});
                    repeat (n * (maj == MAJ_MAP ? 2 : 1)) gen_item(depth + 1);
                end
            end
            6, 7: begin // tag
                buf_q.push_back({MAJ_TAG, 5'($urandom_range(0, 24))});
                if (buf_q[$] == {MAJ_TAG, MINOR_ARG1})
                    buf_q.push_back(8'($urandom_range(0, 255)));
                gen_item(depth + 1);
            end
            8: buf_q.push_back({3'($urandom_range(0, 7)), MINOR_INDEF});
            default: buf_q.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    // Directed table: extremes and special cases of several majors.
    row_t dir_rows[$];

    function automatic void add(logic [7:0] b, logic last, logic chk = 0,
                                logic ok = 0, logic [2:0] st = 0, logic [31:0] len = 0);
        row_t r;
        r.b = b; r.last = last; r.chk = chk;
        r.want = '{len: len, status: st, ok: ok};
        dir_rows.push_back(r);
    endfunction

    initial begin
        row_t r;
        int total;

        add(8'h00, 1, 1, 1, STAT_OK, 1);             // smallest integer, right after reset
        add(8'h1C, 1, 1, 0, STAT_RESERVED, 0);       // reserved minor
        add(8'h1B, 0); add(8'hFF, 0); add(8'hFF, 0); add(8'hFF, 0);
        add(8'hFF, 0); add(8'hFF, 0); add(8'hFF, 0); add(8'hFF, 0);
        add(8'hFF, 1, 1, 1, STAT_OK, 9);             // 8-byte argument, all ones
        add(8'h5B, 0); add(8'hFF, 0); add(8'hFF, 0); add(8'hFF, 0);
        add(8'hFF, 0); add(8'h00, 0); add(8'h00, 0); add(8'h00, 0);
        add(8'h00, 1, 1, 0, STAT_TOO_LONG, 0);       // string past length range
        add(8'h9F, 0); add(8'hFF, 1, 1, 1, STAT_OK, 2); // empty indefinite array
        add(8'hFF, 1, 1, 1, STAT_OK, 1);             // stray break
        add(8'h82, 0); add(8'h01, 1, 1, 0, STAT_TRUNCATED, 0);
        add(8'hDF, 0); add(8'hFF, 0); add(8'h7F, 1); // indefinite tag over break, trailing

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        parser_clear();

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            total = n_pred;
            send_byte(r.b, r.last);
            if (r.chk && n_pred > total && verdicts_due[$] !== r.want)
                report("directed table", verdicts_due[$], r.want);
        end

        // Nesting overflow: seventeen open arrays.
        repeat (DEPTH + 1) send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b1);
        // Sixteen levels closed by one byte.
        repeat (DEPTH) send_byte(8'h81, 1'b0);
        send_byte(8'h00, 1'b1);

        // Long hold-off: receiver idles while the sender keeps offering one-byte buffers.
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge aclk);
                hold_off = 1'b0;
            end
            repeat (60) send_byte(8'($urandom_range(0, 23)), 1'b1);
        join

        total = 0;
        while (total < 930) begin
            buf_q.delete();
            gen_item(0);
            case ($urandom_range(0, 9))
                0: buf_q = buf_q[0:$urandom_range(0, buf_q.size() - 1)];   // truncated
                1: repeat ($urandom_range(1, 3)) buf_q.push_back(8'($urandom_range(0, 255)));
                2: buf_q[$urandom_range(0, buf_q.size() - 1)] = 8'($urandom_range(0, 255));
                default: ;
            endcase
            foreach (buf_q[i]) send_byte(buf_q[i], i == buf_q.size() - 1);
            total += buf_q.size();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (verdicts_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d verdicts (%0d well formed, %0d rejected) over random,",
                 n_results, n_ok, n_bad);
        $display("nested, truncated and corrupted buffers plus a long output stall.");
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end

endmodule
